/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the escape codec RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, disabled while reset is high.
`define UHEC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Checked on every rising clock edge, reset included.
`define UHEC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

/* hdl/uhec_pkg.sv */
// ----------------------------------------------------------------------------
// uhec_pkg
// Types, constants and character helpers shared by the escape codec modules.
// ----------------------------------------------------------------------------
package uhec_pkg;

   // Character constants.
   localparam logic [7:0] ESC_CHAR    = 8'h5F;
   localparam logic [7:0] LETTER_GAP  = 8'd7;
   localparam logic [7:0] NIBBLE_MASK = 8'h0F;

   // Register map.
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned CSR_IDX_W   = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_DECODE_MODE = '0;

   // Default depth of the job queue between front and back.
   localparam int unsigned UHEC_QUEUE_DEPTH = 2;

   // Maximum output bytes that one input byte can produce.
   localparam int unsigned MAX_CHARS = 3;

   // Decode escape phase.
   typedef enum logic [1:0] {
      PHASE_IDLE  = 2'd0,
      PHASE_ESC   = 2'd1,
      PHASE_DIGIT = 2'd2
   } phase_type;

   // Control from the register block to the front.
   typedef struct packed {
      logic decode_mode;
      logic clear;
   } cfg_type;

   // One classified item: up to three output characters, first in chars[0].
   typedef struct packed {
      logic [MAX_CHARS-1:0][7:0] chars;
      logic [1:0]                count;
      logic                      last;
   } job_type;

   function automatic logic is_alnum(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_hex_up(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46);
   endfunction

   // Value of an uppercase hex digit character.
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      v = c - 8'h30;
      if (c > 8'h39) begin
         v = v - LETTER_GAP;
      end
      v = v & NIBBLE_MASK;
      return v[3:0];
   endfunction

   // Uppercase hex digit character for a nibble.
   function automatic logic [7:0] hex_char(input logic [3:0] n);
      logic [7:0] c;
      c = 8'h30 + {4'b0000, n};
      if (n > 4'd9) begin
         c = c + LETTER_GAP;
      end
      return c;
   endfunction

endpackage

/* hdl/underscore_hex_escape_codec.sv */
// The first output word of an input word is registered in the job queue and
// then in the output register.
// Throughput: one input word per cycle while each yields one output word and
// rsp_stall is low; a word that expands to three characters is sent through
// the single output register one character at a time, later words waiting.
// Reset: synchronous, active high; encode mode, no escape held, queue empty.
// ----------------------------------------------------------------------------
// underscore_hex_escape_codec
// Byte stream escape codec with an APB-style mode register, a classifying
// front, a short job queue and a serializing back.
// ----------------------------------------------------------------------------
module underscore_hex_escape_codec #(
   parameter int unsigned QueueDepth = uhec_pkg::UHEC_QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   // Input channel.
   input  logic                            req_valid,
   input  logic [7:0]                      req_in_byte,
   input  logic                            req_in_last,
   output logic                            req_stall,
   // Result channel.
   output logic                            rsp_valid,
   output logic [7:0]                      rsp_out_byte,
   output logic                            rsp_out_last,
   input  logic                            rsp_stall,
   // Register port.
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [uhec_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [uhec_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [uhec_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import uhec_pkg::*;

   logic                 decode_mode_ff, decode_mode_in;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic                 mode_hit;
   logic                 mode_write;
   cfg_type              cfg;
   job_type              push_job;
   job_type              head_job;
   logic                 push;
   logic                 pop;
   logic                 q_empty;
   logic                 q_full;

   // Register decode.
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign mode_hit   = (csr_idx == CSR_IDX_DECODE_MODE);
   assign mode_write = csr_psel && csr_penable && csr_pwrite && csr_pready && mode_hit;

   assign decode_mode_in = mode_write ? csr_pwdata[0] : decode_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         decode_mode_ff <= 1'b0;
      end else begin
         decode_mode_ff <= decode_mode_in;
      end
   end

   // Read back.
   always_comb begin
      csr_prdata = '0;
      if (mode_hit) begin
         csr_prdata[0] = decode_mode_ff;
      end
   end

   // A mode write also drops any held escape.
   assign cfg.decode_mode = decode_mode_ff;
   assign cfg.clear       = mode_write;

   uhec_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .req_stall   (req_stall),
      .q_full      (q_full),
      .push        (push),
      .job         (push_job)
   );

   uhec_fifo #(
      .Depth (QueueDepth)
   ) u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wr_job (push_job),
      .pop    (pop),
      .head   (head_job),
      .empty  (q_empty),
      .full   (q_full)
   );

   uhec_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head_job),
      .empty        (q_empty),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last),
      .rsp_stall    (rsp_stall)
   );

endmodule

/* hdl/uhec_front.sv */
// ----------------------------------------------------------------------------
// uhec_front
// Accepts input words, tracks the decode escape phase and turns each word
// that yields output into a job of up to three output characters for the queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uhec_front (
   input  logic              clock,
   input  logic              reset,
   input  uhec_pkg::cfg_type cfg,
   input  logic              req_valid,
   input  logic [7:0]        req_in_byte,
   input  logic              req_in_last,
   output logic              req_stall,
   input  logic              q_full,
   output logic              push,
   output uhec_pkg::job_type job
);
   import uhec_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   logic       accept;
   logic       b_is_esc_held;

   // The queue decides whether a word can be taken.
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // An underscore that is not the last character opens a new escape.
   assign b_is_esc_held = (req_in_byte == ESC_CHAR) && !req_in_last;

   // Next escape phase.
   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      if (cfg.clear) begin
         phase_in = PHASE_IDLE;
         held_in  = '0;
      end else if (accept && cfg.decode_mode) begin
         unique case (phase_ff)
            PHASE_ESC: begin
               if (req_in_last) begin
                  phase_in = PHASE_IDLE;
               end else if (is_hex_up(req_in_byte)) begin
                  held_in  = req_in_byte;
                  phase_in = PHASE_DIGIT;
               end else begin
                  phase_in = b_is_esc_held ? PHASE_ESC : PHASE_IDLE;
               end
            end
            PHASE_DIGIT: begin
               held_in = '0;
               if (is_hex_up(req_in_byte)) begin
                  phase_in = PHASE_IDLE;
               end else begin
                  phase_in = b_is_esc_held ? PHASE_ESC : PHASE_IDLE;
               end
            end
            default: begin
               phase_in = b_is_esc_held ? PHASE_ESC : PHASE_IDLE;
            end
         endcase
      end
   end

   // Job contents for the accepted word.
   always_comb begin
      job       = '0;
      job.last  = req_in_last;
      if (!cfg.decode_mode) begin
         if (is_alnum(req_in_byte)) begin
            job.chars[0] = req_in_byte;
            job.count    = 2'd1;
         end else begin
            job.chars[0] = ESC_CHAR;
            job.chars[1] = hex_char(req_in_byte[7:4]);
            job.chars[2] = hex_char(req_in_byte[3:0]);
            job.count    = 2'd3;
         end
      end else begin
         unique case (phase_ff)
            PHASE_ESC: begin
               job.chars[0] = ESC_CHAR;
               job.chars[1] = req_in_byte;
               if (req_in_last) begin
                  job.count = 2'd2;
               end else if (is_hex_up(req_in_byte)) begin
                  job.count = 2'd0;
               end else begin
                  job.count = b_is_esc_held ? 2'd1 : 2'd2;
               end
            end
            PHASE_DIGIT: begin
               if (is_hex_up(req_in_byte)) begin
                  job.chars[0] = {hex_value(held_ff), hex_value(req_in_byte)};
                  job.count    = 2'd1;
               end else begin
                  job.chars[0] = ESC_CHAR;
                  job.chars[1] = held_ff;
                  job.chars[2] = req_in_byte;
                  job.count    = b_is_esc_held ? 2'd2 : 2'd3;
               end
            end
            default: begin
               job.chars[0] = req_in_byte;
               job.count    = b_is_esc_held ? 2'd0 : 2'd1;
            end
         endcase
      end
   end

   // Words that only open or extend an escape produce no job.
   assign push = accept && (job.count != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         held_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

   // Encode mode never disturbs the decode phase.
   `UHEC_ASSERT(a_encode_keeps_phase,
      !cfg.decode_mode && !cfg.clear |=> $stable(phase_ff),
      "escape phase changed in encode mode")

endmodule

/* hdl/uhec_fifo.sv */
// ----------------------------------------------------------------------------
// uhec_fifo
// Short job queue that decouples the classifying front from the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uhec_fifo #(
   parameter int unsigned Depth = uhec_pkg::UHEC_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  uhec_pkg::job_type wr_job,
   input  logic              pop,
   output uhec_pkg::job_type head,
   output logic              empty,
   output logic              full
);
   import uhec_pkg::*;

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

   job_type              entries_ff [Depth];
   logic [PtrW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]      count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CntW'(Depth));
   assign head  = entries_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= wr_job;
      end
   end

   // No overflow and no underflow.
   `UHEC_ASSERT(a_queue_bounds,
      !(push && full && !pop) && !(pop && empty),
      "job queue overflow or underflow")

endmodule

/* hdl/uhec_back.sv */
// ----------------------------------------------------------------------------
// uhec_back
// Takes jobs from the queue and sends their characters one word per cycle
// through the output register while a job is queued and rsp_stall is low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uhec_back (
   input  logic              clock,
   input  logic              reset,
   input  uhec_pkg::job_type head,
   input  logic              empty,
   output logic              pop,
   output logic              rsp_valid,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_out_last,
   input  logic              rsp_stall
);
   import uhec_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       advance;
   logic       take;
   logic       at_end;

   // The output register moves when it is empty or being taken.
   assign advance = !valid_ff || !rsp_stall;
   assign take    = advance && !empty;
   assign at_end  = (idx_ff == head.count - 2'd1);
   assign pop     = take && at_end;

   // Serialize the head job.
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (advance) begin
         valid_in = !empty;
      end
      if (take) begin
         byte_in = head.chars[idx_ff];
         last_in = head.last && at_end;
         idx_in  = at_end ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_out_last = last_ff;

   // The character index stays inside the head job.
   `UHEC_ASSERT(a_idx_in_job,
      !empty |-> (idx_ff < head.count),
      "character index beyond job length")

endmodule
